// ===== rtl/rcbd_pkg.sv =====
// shared types, constants and elaboration-time tables for the chunk boundary detector
// no dependencies

package rcbd_pkg;

  localparam int WINDOW = 32;
  localparam int POS_W  = $clog2(WINDOW);
  localparam int LEN_W  = 21;
  localparam int FP_W   = 63;

  localparam logic [63:0] RABIN_POLY = 64'hbfe6b8a5bf378d83;
  localparam logic [63:0] TOP_BIT    = 64'h8000000000000000;

  // configuration register indexes
  localparam logic [1:0] CFG_AVG = 2'd0;
  localparam logic [1:0] CFG_MIN = 2'd1;
  localparam logic [1:0] CFG_MAX = 2'd2;

  typedef logic [255:0][FP_W-1:0] tab_t;

  typedef struct packed {
    logic [LEN_W-1:0] mask;
    logic [LEN_W-1:0] target;
    logic [LEN_W-1:0] min_len;
    logic [LEN_W-1:0] max_len;
  } seg_cfg_t;

  typedef struct packed {
    logic             is_boundary;
    logic [FP_W-1:0]  fingerprint;
    logic [LEN_W-1:0] segment_length;
  } seg_res_t;

  // reduce hi:lo modulo the degree-63 polynomial
  function automatic logic [63:0] gf_mod(logic [63:0] hi_in, logic [63:0] lo_in);
    logic [63:0] hi;
    logic [63:0] lo;
    hi = hi_in;
    lo = lo_in;
    if (hi != '0) begin
      if (hi[63]) hi = hi ^ RABIN_POLY;
      for (int b = 62; b >= 0; b--) begin
        if (hi[b]) begin
          hi = hi ^ (RABIN_POLY >> (63 - b));
          lo = lo ^ (RABIN_POLY << (b + 1));
        end
      end
    end
    if (lo[63]) lo = lo ^ RABIN_POLY;
    return lo;
  endfunction

  // carry-less product, reduced
  function automatic logic [63:0] gf_mulmod(logic [63:0] x, logic [63:0] y);
    logic [63:0] hi;
    logic [63:0] lo;
    hi = '0;
    lo = x[0] ? y : '0;
    for (int b = 1; b < 64; b++) begin
      if (x[b]) begin
        hi = hi ^ (y >> (64 - b));
        lo = lo ^ (y << b);
      end
    end
    return gf_mod(hi, lo);
  endfunction

  function automatic logic [63:0] tab_in_entry(logic [7:0] idx);
    logic [63:0] t1;
    t1 = gf_mod(64'h0, TOP_BIT);
    return gf_mulmod({56'h0, idx}, t1) | {idx[0], 63'h0};
  endfunction

  // both tables are linear in the index, so build from eight basis entries
  function automatic tab_t build_tab_in();
    tab_t        tab;
    logic [63:0] basis [8];
    logic [63:0] acc;
    logic [7:0]  idx;
    for (int b = 0; b < 8; b++) basis[b] = tab_in_entry(8'(1) << b);
    for (int i = 0; i < 256; i++) begin
      idx = 8'(i);
      acc = '0;
      for (int b = 0; b < 8; b++) if (idx[b]) acc = acc ^ basis[b];
      tab[i] = acc[FP_W-1:0];
    end
    return tab;
  endfunction

  // contribution of the byte leaving the window, already pushed through the in table:
  // {u[54:0], 8'h0} ^ in_table[u[62:55]] where u is the out table entry
  function automatic tab_t build_tab_old();
    tab_t        tab;
    tab_t        tin;
    logic [63:0] span;
    logic [63:0] basis [8];
    logic [63:0] u;
    logic [7:0]  idx;
    tin  = build_tab_in();
    span = 64'h1;
    for (int i = 1; i < WINDOW; i++) begin
      span = (span << 8) ^ tab_in_entry(span[62:55]);
    end
    for (int b = 0; b < 8; b++) basis[b] = gf_mulmod({56'h0, 8'(1) << b}, span);
    for (int i = 0; i < 256; i++) begin
      idx = 8'(i);
      u   = '0;
      for (int b = 0; b < 8; b++) if (idx[b]) u = u ^ basis[b];
      tab[i] = {u[54:0], 8'h0} ^ tin[u[62:55]];
    end
    return tab;
  endfunction

  localparam tab_t TAB_IN  = build_tab_in();
  localparam tab_t TAB_OLD = build_tab_old();

endpackage

// ===== rtl/rcbd_ring.sv =====
// byte ring of the last WINDOW bytes in a one-port read-old/write-new memory
// depends on rcbd_pkg

module rcbd_ring (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic       restart,
  input  logic [7:0] data_byte,
  output logic [7:0] old_byte
);

  logic [7:0]                     mem [rcbd_pkg::WINDOW];
  logic [7:0]                     rdata_r;
  logic                           old_vld_r;
  logic [rcbd_pkg::POS_W-1:0]     pos_r;
  logic [rcbd_pkg::POS_W-1:0]     pos_nxt;
  logic [rcbd_pkg::WINDOW-1:0]    vld_r;
  logic [rcbd_pkg::WINDOW-1:0]    vld_nxt;

  always_comb begin
    if (restart || pos_r == rcbd_pkg::POS_W'(rcbd_pkg::WINDOW - 1)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end
    vld_nxt          = restart ? '0 : vld_r;
    vld_nxt[pos_nxt] = 1'b1;
  end

  // a slot never written since reset or restart reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= rcbd_pkg::POS_W'(rcbd_pkg::WINDOW - 1);
      vld_r     <= '0;
      old_vld_r <= 1'b0;
    end else if (acc) begin
      pos_r     <= pos_nxt;
      vld_r     <= vld_nxt;
      old_vld_r <= !restart && vld_r[pos_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rdata_r      <= mem[pos_nxt];
      mem[pos_nxt] <= data_byte;
    end
  end

  assign old_byte = old_vld_r ? rdata_r : 8'h0;

endmodule

// ===== rtl/rcbd_update.sv =====
// fingerprint and segment count update with boundary decision
// depends on rcbd_pkg

module rcbd_update (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                restart,
  input  logic [7:0]          data_byte,
  input  logic [7:0]          old_byte,
  input  rcbd_pkg::seg_cfg_t  cfg,
  output rcbd_pkg::seg_res_t  res
);

  logic [rcbd_pkg::FP_W-1:0]  hash_r;
  logic [rcbd_pkg::FP_W-1:0]  hash_prev;
  logic [rcbd_pkg::FP_W-1:0]  hash_nxt;
  logic [rcbd_pkg::LEN_W-1:0] cnt_r;
  logic [rcbd_pkg::LEN_W-1:0] cnt_prev;
  logic [rcbd_pkg::LEN_W-1:0] cnt_inc;
  logic                       hit;

  always_comb begin
    hash_prev = restart ? '0 : hash_r;
    cnt_prev  = restart ? '0 : cnt_r;
    // in table is linear, so the outgoing byte term is looked up in parallel
    hash_nxt  = {hash_prev[54:0], data_byte}
              ^ rcbd_pkg::TAB_IN[hash_prev[62:55]]
              ^ rcbd_pkg::TAB_OLD[old_byte];
    cnt_inc   = cnt_prev + 1'b1;
    hit       = (cnt_inc >= cfg.min_len) &&
                (((hash_nxt[rcbd_pkg::LEN_W-1:0] & cfg.mask) == cfg.target) ||
                 (cnt_inc == cfg.max_len));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= '0;
      cnt_r  <= '0;
    end else if (adv) begin
      hash_r <= hash_nxt;
      cnt_r  <= hit ? '0 : cnt_inc;
    end
  end

  assign res.is_boundary    = hit;
  assign res.fingerprint    = hash_nxt;
  assign res.segment_length = cnt_inc;

endmodule

// ===== rtl/rabin_chunk_boundary_detector_unit.sv =====
// top level of the rabin content-defined chunk boundary detector
// depends on rcbd_pkg, rcbd_ring, rcbd_update

// Takes one byte per transaction and returns one result per byte: the 63-bit
// rolling fingerprint over the last 32 bytes, the segment length so far and a
// boundary flag. Sustained rate is one byte per cycle while out_ready is high;
// an accepted byte is held in the update stage register and its result then in
// the output register. The ring memory is read and rewritten at the slot of the
// accepted byte in the accept cycle, and the update stage closes the fingerprint
// and count feedback loop into the output register. Restart and reset take
// effect at once (the ring slots carry valid bits, so there is no clearing
// pass). Configuration writes must be made only while the block is idle.

module rabin_chunk_boundary_detector_unit (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [20:0] cfg_wdata,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_restart,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_boundary,
  output logic [62:0] out_fingerprint,
  output logic [20:0] out_segment_length
);

  logic                         in_acc;
  logic                         s1_vld_r;
  logic [7:0]                   s1_byte_r;
  logic                         s1_restart_r;
  logic                         s1_adv;
  logic [7:0]                   old_byte;
  rcbd_pkg::seg_cfg_t           cfg_r;
  rcbd_pkg::seg_res_t           res;
  rcbd_pkg::seg_res_t           out_r;
  logic                         out_vld_r;
  logic [rcbd_pkg::LEN_W-1:0]   avg_smear;

  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // the leading one of the average and all bits below it
  always_comb begin
    avg_smear = cfg_wdata;
    avg_smear = avg_smear | (avg_smear >> 1);
    avg_smear = avg_smear | (avg_smear >> 2);
    avg_smear = avg_smear | (avg_smear >> 4);
    avg_smear = avg_smear | (avg_smear >> 8);
    avg_smear = avg_smear | (avg_smear >> 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mask    <= 21'd8191;
      cfg_r.target  <= 21'd8191;
      cfg_r.min_len <= 21'd2048;
      cfg_r.max_len <= 21'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        rcbd_pkg::CFG_AVG: begin
          cfg_r.mask   <= avg_smear >> 1;
          cfg_r.target <= cfg_wdata - 1'b1;
        end
        rcbd_pkg::CFG_MIN: cfg_r.min_len <= cfg_wdata;
        rcbd_pkg::CFG_MAX: cfg_r.max_len <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r    <= in_data_byte;
      s1_restart_r <= in_restart;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= res;
    end
  end

  rcbd_ring u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .restart   (in_restart),
    .data_byte (in_data_byte),
    .old_byte  (old_byte)
  );

  rcbd_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (s1_adv),
    .restart   (s1_restart_r),
    .data_byte (s1_byte_r),
    .old_byte  (old_byte),
    .cfg       (cfg_r),
    .res       (res)
  );

  assign out_valid          = out_vld_r;
  assign out_is_boundary    = out_r.is_boundary;
  assign out_fingerprint    = out_r.fingerprint;
  assign out_segment_length = out_r.segment_length;

  // a stalled update stage must block new transactions
  ast_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && out_vld_r && !out_ready) |-> !in_ready)
    else $error("input accepted while update stage is stalled");

  ast_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_vld_r)
    else $error("accepted transaction did not reach update stage");

  ast_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_vld_r)
    else $error("update stage advanced without producing a result");

  ast_boundary_min_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.is_boundary) |-> (out_r.segment_length >= cfg_r.min_len))
    else $error("boundary flagged below minimum segment length");

endmodule
